[rtl/core/fpd_pkg.sv]
// fpd_pkg: shared widths, register codes and the divider status struct
// for the fsk pulse period demodulator; no dependencies
`timescale 1ns / 1ps

package fpd_pkg;

    localparam int PERIOD_WIDTH    = 16;
    localparam int PPB_WIDTH       = 8;
    localparam int DURATION_WIDTH  = 16;
    localparam int BIT_COUNT_WIDTH = 16;
    localparam int CFG_ADDR_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int S_TDATA_WIDTH   = 24;
    localparam int M_TDATA_WIDTH   = 24;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_SHORT_PERIOD = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_SHORT_PPB    = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_LONG_PERIOD  = 2'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_LONG_PPB     = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[rtl/core/fpd_divider.sv]
// fpd_divider: restoring serial divider, one quotient bit per cycle,
// shared subtractor and compare; depends on fpd_pkg
`timescale 1ns / 1ps

module fpd_divider #(
    parameter int QW = 17
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [QW-1:0]                 dividend,
    input  logic [fpd_pkg::PPB_WIDTH-1:0] divisor,
    output logic [QW-1:0]                 quotient,
    output fpd_pkg::div_status_t          status
);

    localparam int CNT_W = $clog2(QW);
    localparam int PW    = fpd_pkg::PPB_WIDTH;

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [QW-1:0]     quo_reg, quo_next;
    logic [PW-1:0]     rem_reg, rem_next;
    logic [PW-1:0]     div_reg, div_next;
    logic [PW:0]       trial;
    logic [PW:0]       diff;
    logic              last_step;

    // remainder stays below the divisor, so PW bits hold it
    assign trial     = {rem_reg, quo_reg[QW-1]};
    assign diff      = trial - {1'b0, div_reg};
    assign last_step = busy_reg && (cnt_reg == CNT_W'(QW - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[PW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[PW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = last_step;

endmodule

[rtl/core/fsk_pulse_period_demodulator.sv]
// fsk_pulse_period_demodulator: period-counting fsk demodulator top level
// depends on fpd_pkg and fpd_divider
// result: a transaction that ends no run gives its result in the next cycle; when a run
// ends, the bit count comes from the serial divider (one quotient bit per cycle) via S_DIV, S_DONE
// throughput: one transaction per cycle while no run ends and the output is taken,
// otherwise the next transaction waits until the divided bit count reaches the output
// reset: asynchronous, clears state and output valid, registers go to 0, 1, 0, 1
`timescale 1ns / 1ps

module fsk_pulse_period_demodulator #(
    parameter int ACC_WIDTH   = 20,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] level_high, [16:1] duration, [23:17] zero
    input  logic [fpd_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] bit_value, [16:1] bit_count, [23:17] zero
    output logic [fpd_pkg::M_TDATA_WIDTH-1:0]   m_tdata,
    input  logic                                cfg_we,
    input  logic [fpd_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
    input  logic [fpd_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);

    localparam int PW  = fpd_pkg::PERIOD_WIDTH;
    localparam int BW  = fpd_pkg::PPB_WIDTH;
    localparam int DW  = fpd_pkg::DURATION_WIDTH;
    localparam int CW  = fpd_pkg::BIT_COUNT_WIDTH;
    localparam int QW  = COUNT_WIDTH + 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;

    logic [PW-1:0]          short_period_reg;
    logic [BW-1:0]          short_ppb_reg;
    logic [PW-1:0]          long_period_reg;
    logic [BW-1:0]          long_ppb_reg;

    logic [ACC_WIDTH-1:0]   period_acc_reg, period_acc_next;
    logic [COUNT_WIDTH-1:0] run_count_reg, run_count_next;
    logic                   last_was_long_reg, last_was_long_next;
    logic                   pend_value_reg, pend_value_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_value_reg, out_value_next;
    logic [CW-1:0]          out_count_reg, out_count_next;

    logic                   accept;
    logic                   out_free;
    logic                   level_high;
    logic [DW-1:0]          duration;

    logic [PW-1:0]          lo_t, hi_t, mid;
    logic [BW-1:0]          lo_p, hi_p, sel_p;
    logic                   inv;
    logic [ACC_WIDTH:0]     acc_sum;
    logic [ACC_WIDTH-1:0]   acc_new;
    logic                   in_range;
    logic                   cls;
    logic [COUNT_WIDTH-1:0] run_inc;
    logic                   run_end;

    logic                   div_start;
    logic [QW-1:0]          div_dividend;
    logic [BW-1:0]          div_divisor;
    logic [QW-1:0]          div_quotient;
    fpd_pkg::div_status_t   div_status;
    logic [QW+CW-1:0]       quo_ext;
    logic [CW-1:0]          quo_sat;

    assign level_high = s_tdata[0];
    assign duration   = s_tdata[DW:1];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // order the two settings, invert the bit when they come swapped
    always_comb
    begin
        inv  = short_period_reg > long_period_reg;
        lo_t = inv ? long_period_reg  : short_period_reg;
        hi_t = inv ? short_period_reg : long_period_reg;
        lo_p = inv ? long_ppb_reg     : short_ppb_reg;
        hi_p = inv ? short_ppb_reg    : long_ppb_reg;
        mid  = lo_t + ((hi_t - lo_t) >> 1);
    end

    always_comb
    begin
        acc_sum  = {1'b0, period_acc_reg} + (ACC_WIDTH + 1)'(duration);
        acc_new  = acc_sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : acc_sum[ACC_WIDTH-1:0];
        in_range = (acc_new >= ACC_WIDTH'(lo_t)) && (acc_new < ACC_WIDTH'(hi_t));
        cls      = acc_new >= ACC_WIDTH'(mid);
        run_inc  = (&run_count_reg) ? run_count_reg : run_count_reg + COUNT_WIDTH'(1);
        run_end  = !level_high && in_range && (cls != last_was_long_reg);
        sel_p    = last_was_long_reg ? hi_p : lo_p;
    end

    assign div_start    = accept && run_end;
    assign div_dividend = {1'b0, run_inc} + QW'(1);
    assign div_divisor  = (sel_p == '0) ? BW'(1) : sel_p;

    fpd_divider #(
        .QW (QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // bit count saturates at the field width
    assign quo_ext = {{CW{1'b0}}, div_quotient};
    assign quo_sat = (|quo_ext[QW+CW-1:CW]) ? {CW{1'b1}} : quo_ext[CW-1:0];

    always_comb
    begin
        state_next         = state_reg;
        period_acc_next    = period_acc_reg;
        run_count_next     = run_count_reg;
        last_was_long_next = last_was_long_reg;
        pend_value_next    = pend_value_reg;
        out_valid_next     = out_valid_reg;
        out_value_next     = out_value_reg;
        out_count_next     = out_count_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (level_high)
                    begin
                        period_acc_next = ACC_WIDTH'(duration);
                    end
                    else
                    begin
                        period_acc_next = acc_new;
                        if (!in_range)
                        begin
                            run_count_next = '0;
                        end
                        else if (run_end)
                        begin
                            run_count_next     = '0;
                            last_was_long_next = cls;
                            pend_value_next    = last_was_long_reg ^ inv;
                        end
                        else
                        begin
                            run_count_next = run_inc;
                        end
                    end
                    if (run_end)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = 1'b0;
                        out_count_next = '0;
                    end
                end
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = pend_value_reg;
                    out_count_next = quo_sat;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            period_acc_reg    <= '0;
            run_count_reg     <= '0;
            last_was_long_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            period_acc_reg    <= period_acc_next;
            run_count_reg     <= run_count_next;
            last_was_long_reg <= last_was_long_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_value_reg <= pend_value_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_period_reg <= '0;
            short_ppb_reg    <= BW'(1);
            long_period_reg  <= '0;
            long_ppb_reg     <= BW'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                fpd_pkg::REG_SHORT_PERIOD: short_period_reg <= cfg_wdata[PW-1:0];
                fpd_pkg::REG_SHORT_PPB:    short_ppb_reg    <= cfg_wdata[BW-1:0];
                fpd_pkg::REG_LONG_PERIOD:  long_period_reg  <= cfg_wdata[PW-1:0];
                fpd_pkg::REG_LONG_PPB:     long_ppb_reg     <= cfg_wdata[BW-1:0];
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(fpd_pkg::M_TDATA_WIDTH - CW - 1){1'b0}}, out_count_reg, out_value_reg};

endmodule

[rtl/core/fpd_checker.sv]
// fpd_checker: port-level assertions for the demodulator top level
// depends on fpd_pkg; bound to fsk_pulse_period_demodulator below
`timescale 1ns / 1ps

module fpd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [fpd_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [fpd_pkg::M_TDATA_WIDTH-1:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // a high half-period taken with no result pending gives an empty result in the next cycle
    a_high_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[0] && !m_tvalid
        |=> m_tvalid && (m_tdata[16:0] == 17'd0))
        else $error("high half-period result not empty");

    // a new transaction is taken only when the pending result drains
    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && m_tvalid |-> m_tready)
        else $error("input ready while output stalled");

endmodule

bind fsk_pulse_period_demodulator fpd_checker u_fpd_checker (.*);
